/* rtl/sigmoid_neuron_forward_and_update_defines.svh */
`ifndef SIGMOID_NEURON_FORWARD_AND_UPDATE_DEFINES_SVH
`define SIGMOID_NEURON_FORWARD_AND_UPDATE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define SNFU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SNFU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/snfu_pkg.sv */
package snfu_pkg;

   localparam int DATA_W              = 16;
   localparam int Q_SHIFT             = 12;
   localparam int NUM_X               = 8;
   localparam int MAX_FAN_IN_DEF      = 8;
   localparam int SIGMOID_ENTRIES_DEF = 256;

   localparam int FAN_IN_W  = 4;
   localparam int LR_W      = 15;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_W     = 2;

   localparam int FWD_PROD_W = 2 * DATA_W;
   localparam int GMUL_W     = 2 * DATA_W + 1;
   localparam int G_W        = GMUL_W - Q_SHIFT;
   localparam int GDP_W      = 2 * G_W;
   localparam int GD_W       = GDP_W - Q_SHIFT;
   localparam int PROD_W     = GD_W + DATA_W;
   localparam int WIDE_W     = 48;

   localparam int REQ_TDATA_W = DATA_W * (NUM_X + 1);
   localparam int RSP_BITS    = 2 * DATA_W + 1;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;

   localparam logic [REQ_W-1:0] REQ_FWD  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_UPD  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_INIT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FAN_IN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LR     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_W = 2'd2;

   localparam logic [FAN_IN_W-1:0]      FAN_IN_RST = 4'd2;
   localparam logic [LR_W-1:0]          LR_RST     = 15'd2048;
   localparam logic signed [DATA_W-1:0] INIT_W_RST = 16'sd2048;
   localparam logic signed [DATA_W-1:0] WEIGHT_RST = 16'sd2048;
   localparam logic signed [DATA_W-1:0] ONE_Q      = 16'sd4096;

   localparam logic signed [WIDE_W-1:0] SAT_HI = 48'sd32767;
   localparam logic signed [WIDE_W-1:0] SAT_LO = -48'sd32768;

   typedef struct packed {
      logic load;
      logic load_fwd;
      logic mul_fwd;
      logic grad1;
      logic sum;
      logic grad2;
      logic look;
      logic mul_upd;
      logic commit_fwd;
      logic commit_upd;
      logic commit_init;
   } snfu_ctl_type;

   typedef struct packed {
      logic                     sat;
      logic signed [DATA_W-1:0] val;
   } sat16_type;

   function automatic sat16_type sat16(input logic signed [WIDE_W-1:0] v);
      sat16_type r;
      r.sat = 1'b0;
      r.val = v[DATA_W-1:0];
      if (v > SAT_HI) begin
         r.sat = 1'b1;
         r.val = SAT_HI[DATA_W-1:0];
      end else if (v < SAT_LO) begin
         r.sat = 1'b1;
         r.val = SAT_LO[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/snfu_lane.sv */
module snfu_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  snfu_pkg::snfu_ctl_type                ctl,
   input  logic                                  lane_en,
   input  logic signed [snfu_pkg::DATA_W-1:0]    x_in,
   input  logic signed [snfu_pkg::DATA_W-1:0]    init_weight,
   input  logic signed [snfu_pkg::GD_W-1:0]      gd,
   output logic signed [snfu_pkg::PROD_W-1:0]    prod,
   output logic                                  lane_sat
);

   logic signed [snfu_pkg::DATA_W-1:0] weight_ff, weight_in;
   logic signed [snfu_pkg::DATA_W-1:0] last_x_ff, last_x_in;
   logic signed [snfu_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [snfu_pkg::GD_W-1:0]   mul_a;
   snfu_pkg::sat16_type                ws;

   // shared multiplier: weight * x on forward, gd * x on update
   always_comb begin
      mul_a   = ctl.mul_upd ? gd : snfu_pkg::GD_W'(weight_ff);
      prod_in = prod_ff;
      if (ctl.mul_fwd || ctl.mul_upd) begin
         prod_in = snfu_pkg::PROD_W'(mul_a) * snfu_pkg::PROD_W'(last_x_ff);
      end
   end

   always_comb begin
      ws = snfu_pkg::sat16(snfu_pkg::WIDE_W'(weight_ff)
                           - snfu_pkg::WIDE_W'(prod_ff >>> snfu_pkg::Q_SHIFT));
      weight_in = weight_ff;
      lane_sat  = 1'b0;
      if (ctl.commit_init) begin
         weight_in = init_weight;
      end else if (ctl.commit_upd && lane_en) begin
         weight_in = ws.val;
         lane_sat  = ws.sat;
      end
      last_x_in = ctl.load_fwd ? x_in : last_x_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= snfu_pkg::WEIGHT_RST;
         last_x_ff <= '0;
      end else begin
         weight_ff <= weight_in;
         last_x_ff <= last_x_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* rtl/snfu_merge.sv */
module snfu_merge #(
   parameter int MAX_FAN_IN      = snfu_pkg::MAX_FAN_IN_DEF,
   parameter int SIGMOID_ENTRIES = snfu_pkg::SIGMOID_ENTRIES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  snfu_pkg::snfu_ctl_type                ctl,
   input  logic [MAX_FAN_IN-1:0]                 lane_en,
   input  logic                                  sensor,
   input  logic signed [snfu_pkg::DATA_W-1:0]    x0,
   input  logic signed [snfu_pkg::DATA_W-1:0]    err,
   input  logic [snfu_pkg::LR_W-1:0]             lr,
   input  logic signed [snfu_pkg::PROD_W-1:0]    lane_prod [MAX_FAN_IN],
   output logic signed [snfu_pkg::GD_W-1:0]      gd,
   output logic signed [snfu_pkg::DATA_W-1:0]    act_next,
   output logic signed [snfu_pkg::DATA_W-1:0]    bias_next,
   output logic                                  msat
);

   localparam int ACC_W = snfu_pkg::FWD_PROD_W + $clog2(MAX_FAN_IN + 1) + 2;
   localparam int IDX_W = $clog2(SIGMOID_ENTRIES);
   localparam int DW    = snfu_pkg::DATA_W;

   typedef logic [DW-1:0] sig_tbl_type [SIGMOID_ENTRIES];

   // shift and subtract quotient of two non-negative values, elaboration only
   function automatic longint udiv(input longint num, input longint den);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         r = (r << 1) | ((num >> b) & 64'sd1);
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 64'sd1;
         end
      end
      return q;
   endfunction

   // sigmoid at bin centers over -8..8, Q4.12
   function automatic sig_tbl_type sig_build();
      sig_tbl_type tbl;
      longint      q30;
      longint      m;
      longint      am;
      longint      u;
      longint      term;
      longint      e;
      longint      s;
      tbl = '{default: '0};
      q30 = 64'sd1 << 30;
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
         m    = 2 * longint'(k) + 1 - longint'(SIGMOID_ENTRIES);
         am   = (m < 0) ? -m : m;
         u    = udiv(am << 30, 2 * longint'(SIGMOID_ENTRIES));
         term = q30;
         e    = q30;
         for (int j = 1; j <= 12; j++) begin
            term = udiv((term * u) >> 30, longint'(j));
            if (j[0]) begin
               e = e - term;
            end else begin
               e = e + term;
            end
         end
         if (e < 0) begin
            e = 0;
         end
         for (int i = 0; i < 4; i++) begin
            e = (e * e) >> 30;
         end
         s = udiv((64'sd4096 << 30) + ((q30 + e) >> 1), q30 + e);
         tbl[k] = (m < 0) ? DW'(64'sd4096 - s) : DW'(s);
      end
      return tbl;
   endfunction

   localparam sig_tbl_type SIG_TABLE = sig_build();

   logic signed [DW-1:0]                    act_ff, bias_ff;
   logic signed [DW-1:0]                    x0_ff, err_ff;
   logic signed [snfu_pkg::GMUL_W-1:0]      dmul_ff, dmul_in, gmul_ff, gmul_in;
   logic signed [snfu_pkg::GD_W-1:0]        gd_ff, gd_in;
   logic signed [ACC_W-1:0]                 acc_ff, acc_in;
   logic signed [DW-1:0]                    look_act_ff, look_act_in;
   logic                                    look_sat_ff, look_sat_in;
   logic signed [snfu_pkg::G_W-1:0]         g_val, d_val;
   logic signed [snfu_pkg::GDP_W-1:0]       gd_full;
   snfu_pkg::sat16_type                     sum_sat, bias_sat;
   logic [DW-1:0]                           sum_u;
   logic [31:0]                             idx_prod;
   logic [IDX_W-1:0]                        idx;

   // gradient chain: out*(1-out), lr*err, then their product
   always_comb begin
      dmul_in = dmul_ff;
      gmul_in = gmul_ff;
      if (ctl.grad1) begin
         dmul_in = snfu_pkg::GMUL_W'(act_ff)
                   * (snfu_pkg::GMUL_W'(snfu_pkg::ONE_Q) - snfu_pkg::GMUL_W'(act_ff));
         gmul_in = snfu_pkg::GMUL_W'(signed'({1'b0, lr})) * snfu_pkg::GMUL_W'(err_ff);
      end
      g_val   = signed'(gmul_ff[snfu_pkg::GMUL_W-1:snfu_pkg::Q_SHIFT]);
      d_val   = signed'(dmul_ff[snfu_pkg::GMUL_W-1:snfu_pkg::Q_SHIFT]);
      gd_full = snfu_pkg::GDP_W'(g_val) * snfu_pkg::GDP_W'(d_val);
      gd_in   = ctl.grad2 ? signed'(gd_full[snfu_pkg::GDP_W-1:snfu_pkg::Q_SHIFT]) : gd_ff;
   end

   // adder tree over connected lanes plus bias
   always_comb begin
      acc_in = acc_ff;
      if (ctl.sum) begin
         acc_in = ACC_W'(bias_ff) <<< snfu_pkg::Q_SHIFT;
         for (int i = 0; i < MAX_FAN_IN; i++) begin
            if (lane_en[i]) begin
               acc_in = acc_in + ACC_W'(signed'(lane_prod[i][snfu_pkg::FWD_PROD_W-1:0]));
            end
         end
      end
   end

   // clamp, index and table lookup
   always_comb begin
      sum_sat     = snfu_pkg::sat16(snfu_pkg::WIDE_W'(acc_ff >>> snfu_pkg::Q_SHIFT));
      sum_u       = {~sum_sat.val[DW-1], sum_sat.val[DW-2:0]};
      idx_prod    = 32'(sum_u) * 32'(SIGMOID_ENTRIES);
      idx         = idx_prod[16 +: IDX_W];
      look_act_in = look_act_ff;
      look_sat_in = look_sat_ff;
      if (ctl.look) begin
         look_act_in = signed'(SIG_TABLE[idx]);
         look_sat_in = sum_sat.sat;
      end
   end

   always_comb begin
      bias_sat  = snfu_pkg::sat16(snfu_pkg::WIDE_W'(bias_ff) - snfu_pkg::WIDE_W'(gd_ff));
      act_next  = act_ff;
      bias_next = bias_ff;
      msat      = 1'b0;
      if (ctl.commit_fwd) begin
         act_next = sensor ? x0_ff : look_act_ff;
         msat     = !sensor && look_sat_ff;
      end else if (ctl.commit_upd) begin
         bias_next = bias_sat.val;
         msat      = bias_sat.sat;
      end else if (ctl.commit_init) begin
         bias_next = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= '0;
         bias_ff <= '0;
      end else begin
         act_ff  <= act_next;
         bias_ff <= bias_next;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_fwd) begin
         x0_ff <= x0;
      end
      if (ctl.load) begin
         err_ff <= err;
      end
      dmul_ff     <= dmul_in;
      gmul_ff     <= gmul_in;
      gd_ff       <= gd_in;
      acc_ff      <= acc_in;
      look_act_ff <= look_act_in;
      look_sat_ff <= look_sat_in;
   end

   assign gd = gd_ff;

endmodule

/* rtl/sigmoid_neuron_forward_and_update.sv */
// Channel   Dir  Handshake            Payload
// req       in   req_tvalid/tready    tuser: req_type; tdata: x0..x7, error_value
// rsp       out  rsp_tvalid/tready    tdata: activation, bias_value, saturated
// csr       in   csr_wen              csr_index, csr_wdata
//
// Each item passes through four steps: lane multiply / gradient products, adder
// tree / gd product, sigmoid lookup / lane update multiply, commit.
// The result register loads on commit; the next request is taken on that edge.
// A full result register holds the commit until rsp transfers.
// Reset is synchronous: weights 2048, bias, activation and stored lane inputs 0.
module sigmoid_neuron_forward_and_update #(
   parameter int MAX_FAN_IN      = snfu_pkg::MAX_FAN_IN_DEF,
   parameter int SIGMOID_ENTRIES = snfu_pkg::SIGMOID_ENTRIES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // x0, x1, x2, x3, x4, x5, x6, x7, error_value
   input  logic [snfu_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // req_type
   input  logic [snfu_pkg::REQ_W-1:0]            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // activation, bias_value, saturated, zero fill
   output logic [snfu_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_wen,
   input  logic [snfu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [snfu_pkg::DATA_W-1:0]           csr_wdata
);

   `include "sigmoid_neuron_forward_and_update_defines.svh"

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_P1   = 3'd1;
   localparam logic [2:0] ST_P2   = 3'd2;
   localparam logic [2:0] ST_P3   = 3'd3;
   localparam logic [2:0] ST_P4   = 3'd4;

   localparam int DW = snfu_pkg::DATA_W;

   logic [2:0]                         state_ff, state_in;
   logic [snfu_pkg::REQ_W-1:0]         op_ff, op_in;
   logic [snfu_pkg::FAN_IN_W-1:0]      fan_in_ff;
   logic [snfu_pkg::LR_W-1:0]          lr_ff;
   logic signed [DW-1:0]               init_w_ff;
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [snfu_pkg::RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                               accept, commit;
   snfu_pkg::snfu_ctl_type             ctl;
   logic [MAX_FAN_IN-1:0]              lane_en;
   logic [MAX_FAN_IN-1:0]              lane_sat;
   logic signed [snfu_pkg::PROD_W-1:0] lane_prod [MAX_FAN_IN];
   logic signed [snfu_pkg::GD_W-1:0]   gd;
   logic signed [DW-1:0]               act_next, bias_next;
   logic                               msat;

   assign commit     = (state_ff == ST_P4) && (!rsp_tvalid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE) || commit;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      op_in    = accept ? req_tuser : op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_P1;
            end
         end
         ST_P1: state_in = ST_P2;
         ST_P2: state_in = ST_P3;
         ST_P3: state_in = ST_P4;
         ST_P4: begin
            if (commit) begin
               state_in = accept ? ST_P1 : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl             = '0;
      ctl.load        = accept;
      ctl.load_fwd    = accept && (req_tuser == snfu_pkg::REQ_FWD);
      ctl.mul_fwd     = (state_ff == ST_P1) && (op_ff == snfu_pkg::REQ_FWD);
      ctl.grad1       = (state_ff == ST_P1) && (op_ff == snfu_pkg::REQ_UPD);
      ctl.sum         = (state_ff == ST_P2) && (op_ff == snfu_pkg::REQ_FWD);
      ctl.grad2       = (state_ff == ST_P2) && (op_ff == snfu_pkg::REQ_UPD);
      ctl.look        = (state_ff == ST_P3) && (op_ff == snfu_pkg::REQ_FWD);
      ctl.mul_upd     = (state_ff == ST_P3) && (op_ff == snfu_pkg::REQ_UPD);
      ctl.commit_fwd  = commit && (op_ff == snfu_pkg::REQ_FWD);
      ctl.commit_upd  = commit && (op_ff == snfu_pkg::REQ_UPD);
      ctl.commit_init = commit && (op_ff == snfu_pkg::REQ_INIT);
   end

   genvar i;
   generate
      for (i = 0; i < MAX_FAN_IN; i++) begin : g_lane
         logic signed [DW-1:0] lane_x;
         if (i < snfu_pkg::NUM_X) begin : g_x
            assign lane_x = signed'(req_tdata[DW*i +: DW]);
         end else begin : g_zero
            assign lane_x = '0;
         end
         assign lane_en[i] = 32'(fan_in_ff) > i;

         snfu_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .lane_en     (lane_en[i]),
            .x_in        (lane_x),
            .init_weight (init_w_ff),
            .gd          (gd),
            .prod        (lane_prod[i]),
            .lane_sat    (lane_sat[i])
         );
      end
   endgenerate

   snfu_merge #(
      .MAX_FAN_IN      (MAX_FAN_IN),
      .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .lane_en   (lane_en),
      .sensor    (fan_in_ff == '0),
      .x0        (signed'(req_tdata[DW-1:0])),
      .err       (signed'(req_tdata[DW*snfu_pkg::NUM_X +: DW])),
      .lr        (lr_ff),
      .lane_prod (lane_prod),
      .gd        (gd),
      .act_next  (act_next),
      .bias_next (bias_next),
      .msat      (msat)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      if (commit) begin
         rsp_tvalid_in = 1'b1;
         rsp_data_in   = {{snfu_pkg::RSP_PAD_W{1'b0}}, msat || (|lane_sat),
                          bias_next, act_next};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= snfu_pkg::REQ_FWD;
         rsp_tvalid_ff <= 1'b0;
         fan_in_ff     <= snfu_pkg::FAN_IN_RST;
         lr_ff         <= snfu_pkg::LR_RST;
         init_w_ff     <= snfu_pkg::INIT_W_RST;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wen && (csr_index == snfu_pkg::CSR_FAN_IN)) begin
            fan_in_ff <= csr_wdata[snfu_pkg::FAN_IN_W-1:0];
         end
         if (csr_wen && (csr_index == snfu_pkg::CSR_LR)) begin
            lr_ff <= csr_wdata[snfu_pkg::LR_W-1:0];
         end
         if (csr_wen && (csr_index == snfu_pkg::CSR_INIT_W)) begin
            init_w_ff <= signed'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SNFU_ASSERT_NEXT(a_accept_starts, accept, state_ff == ST_P1, "accept did not start item")
   `SNFU_ASSERT_NEXT(a_hold_on_full, (state_ff == ST_P4) && rsp_tvalid_ff && !rsp_tready, state_ff == ST_P4, "commit while result register full")
   `SNFU_ASSERT_NEXT(a_init_clears_bias, ctl.commit_init, rsp_tvalid && (rsp_tdata[2*DW-1:DW] == '0), "reinit left bias nonzero")
   `SNFU_ASSERT_NOW(a_no_weight_sat, ctl.commit_fwd || ctl.commit_init, lane_sat == '0, "weight clamp outside update")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int LUT_N = snfu_pkg::SIGMOID_ENTRIES_DEF;
   localparam int LANES = snfu_pkg::NUM_X;
   localparam int DW = snfu_pkg::DATA_W;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint Q30 = 64'sd1 << 30;
   localparam logic [snfu_pkg::REQ_W-1:0] REQ_NONE = 2'd3;

   typedef struct packed {
      logic [snfu_pkg::REQ_W-1:0]  kind;
      logic [DW-1:0]               err;
      logic [LANES-1:0][DW-1:0]    x;
   } neuron_req_type;

   typedef struct packed {
      logic signed [DW-1:0] activation;
      logic signed [DW-1:0] bias_value;
      logic                 saturated;
   } neuron_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [snfu_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [snfu_pkg::REQ_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [snfu_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [snfu_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [DW-1:0] csr_wdata = '0;

   sigmoid_neuron_forward_and_update uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted neuron state
   logic [DW-1:0]                      sigmoid_lut [LUT_N];
   logic [snfu_pkg::FAN_IN_W-1:0]      fan_in_q;
   logic [snfu_pkg::LR_W-1:0]          lr_q;
   logic signed [DW-1:0]               init_w_q;
   logic signed [DW-1:0]               wt [LANES];
   logic signed [DW-1:0]               bias_q;
   logic signed [DW-1:0]               last_in [LANES];
   logic signed [DW-1:0]               last_act;

   neuron_out_type expected_q [$];
   neuron_out_type exp_head;
   int fail_cnt = 0;
   int cycle_cnt = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int stall_left = 0;

   function automatic void build_sigmoid_lut();
      longint m, e, s;
      longint unsigned am, u, term;
      for (int k = 0; k < LUT_N; k++) begin
         m = 2 * k + 1 - LUT_N;
         am = (m < 0) ? -m : m;
         u = (am << 30) / (2 * LUT_N);
         term = 64'd1 << 30;
         e = Q30;
         for (int j = 1; j <= 12; j++) begin
            term = ((term * u) >> 30) / j;
            if (j % 2) e -= term;
            else e += term;
         end
         if (e < 0) e = 0;
         repeat (4) e = (e * e) >>> 30;
         s = ((64'sd4096 << 30) + (Q30 + e) / 2) / (Q30 + e);
         sigmoid_lut[k] = (m < 0) ? DW'(4096 - s) : DW'(s);
      end
   endfunction

   function automatic void neuron_clear();
      fan_in_q = snfu_pkg::FAN_IN_RST;
      lr_q = snfu_pkg::LR_RST;
      init_w_q = snfu_pkg::INIT_W_RST;
      for (int i = 0; i < LANES; i++) begin
         wt[i] = snfu_pkg::WEIGHT_RST;
         last_in[i] = '0;
      end
      bias_q = '0;
      last_act = '0;
   endfunction

   function automatic longint clamp16(longint v, inout logic hit);
      if (v > 32767) begin
         hit = 1'b1;
         return 32767;
      end
      if (v < -32768) begin
         hit = 1'b1;
         return -32768;
      end
      return v;
   endfunction

   function automatic neuron_out_type neuron_predict(neuron_req_type it);
      neuron_out_type r;
      longint acc, total, o, d, g, gd;
      int n;
      logic hit;
      hit = 1'b0;
      n = (fan_in_q > LANES) ? LANES : fan_in_q;
      case (it.kind)
         snfu_pkg::REQ_FWD: begin
            for (int i = 0; i < LANES; i++) last_in[i] = it.x[i];
            if (n == 0) begin
               last_act = it.x[0];
            end else begin
               acc = longint'(bias_q) * 4096;
               for (int i = 0; i < n; i++) acc += longint'(last_in[i]) * longint'(wt[i]);
               total = clamp16(acc >>> 12, hit);
               last_act = sigmoid_lut[((total + 32768) * LUT_N) >> 16];
            end
         end
         snfu_pkg::REQ_UPD: begin
            o = longint'(last_act);
            d = (o * (4096 - o)) >>> 12;
            g = (longint'(lr_q) * longint'($signed(it.err))) >>> 12;
            gd = (g * d) >>> 12;
            for (int i = 0; i < n; i++)
               wt[i] = DW'(clamp16(longint'(wt[i]) - ((gd * longint'(last_in[i])) >>> 12),
                                   hit));
            bias_q = DW'(clamp16(longint'(bias_q) - gd, hit));
         end
         snfu_pkg::REQ_INIT: begin
            for (int i = 0; i < LANES; i++) wt[i] = init_w_q;
            bias_q = '0;
         end
         default: ;
      endcase
      r.activation = last_act;
      r.bias_value = bias_q;
      r.saturated = hit;
      return r;
   endfunction

   function automatic int pick_gap(int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [DW-1:0] rand_q16();
      case ($urandom_range(5))
         0, 1: return DW'($urandom);
         2: return DW'($urandom_range(8191) - 4096);
         3: begin
            case ($urandom_range(3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         4: return DW'($urandom_range(1023) - 512);
         default: return DW'($urandom_range(32767) - 16384);
      endcase
   endfunction

   function automatic neuron_req_type fill_req(logic [snfu_pkg::REQ_W-1:0] kind,
                                               logic [DW-1:0] lane, logic [DW-1:0] err);
      neuron_req_type it;
      it.kind = kind;
      it.err = err;
      for (int i = 0; i < LANES; i++) it.x[i] = lane;
      return it;
   endfunction

   function automatic neuron_req_type rand_req(logic [snfu_pkg::REQ_W-1:0] kind);
      neuron_req_type it;
      it.kind = kind;
      it.err = rand_q16();
      for (int i = 0; i < LANES; i++) it.x[i] = rand_q16();
      return it;
   endfunction

   task automatic send_req(neuron_req_type it);
      int gap;
      gap = pick_gap(req_gap_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.kind;
      req_tdata <= {it.err, it.x};
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(neuron_predict(it));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [snfu_pkg::CSR_IDX_W-1:0] idx, logic [DW-1:0] val);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         snfu_pkg::CSR_FAN_IN: fan_in_q = val[snfu_pkg::FAN_IN_W-1:0];
         snfu_pkg::CSR_LR: lr_q = val[snfu_pkg::LR_W-1:0];
         snfu_pkg::CSR_INIT_W: init_w_q = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_setting(int fan, int lr, logic [DW-1:0] iw);
      csr_write(snfu_pkg::CSR_FAN_IN, DW'(fan));
      csr_write(snfu_pkg::CSR_LR, DW'(lr));
      csr_write(snfu_pkg::CSR_INIT_W, iw);
   endtask

   // reset values, unused request code, forward span and one update at default setting
   task automatic test_reset_and_span();
      send_req(fill_req(REQ_NONE, 16'h1234, 16'h4321));
      send_req(fill_req(snfu_pkg::REQ_FWD, 16'h7FFF, 16'h0000));
      send_req(fill_req(snfu_pkg::REQ_FWD, 16'h8000, 16'h0000));
      send_req(fill_req(snfu_pkg::REQ_UPD, 16'h0000, 16'h1000));
      send_req(fill_req(snfu_pkg::REQ_FWD, 16'h0000, 16'h0000));
      wait_idle();
   endtask

   // clamping of the sum, the weights and the bias
   task automatic test_saturation();
      apply_setting(8, 32767, 16'h7FFF);
      send_req(fill_req(snfu_pkg::REQ_INIT, 16'h0000, 16'h0000));
      send_req(fill_req(snfu_pkg::REQ_FWD, 16'h7FFF, 16'h0000));
      send_req(fill_req(snfu_pkg::REQ_FWD, 16'h8000, 16'h0000));
      send_req(fill_req(snfu_pkg::REQ_FWD, 16'h0400, 16'h0000));
      send_req(fill_req(snfu_pkg::REQ_UPD, 16'h0000, 16'h7FFF));
      send_req(fill_req(snfu_pkg::REQ_UPD, 16'h0000, 16'h8000));
      send_req(fill_req(REQ_NONE, 16'hFFFF, 16'hFFFF));
      wait_idle();
   endtask

   // fan_in zero passes x0 through and only moves the bias on update
   task automatic test_sensor_neuron();
      apply_setting(0, 32767, 16'h8000);
      send_req(fill_req(snfu_pkg::REQ_INIT, 16'h0000, 16'h0000));
      send_req(fill_req(snfu_pkg::REQ_FWD, 16'h8000, 16'h0000));
      send_req(fill_req(snfu_pkg::REQ_UPD, 16'h0000, 16'h7FFF));
      send_req(fill_req(snfu_pkg::REQ_FWD, 16'h7FFF, 16'h0000));
      send_req(fill_req(snfu_pkg::REQ_UPD, 16'h0000, 16'h8000));
      wait_idle();
   endtask

   // fan_in above the lane count behaves as all lanes
   task automatic test_fan_in_overrange();
      apply_setting(15, 0, 16'h0800);
      send_req(fill_req(snfu_pkg::REQ_INIT, 16'h0000, 16'h0000));
      send_req(rand_req(snfu_pkg::REQ_FWD));
      send_req(rand_req(snfu_pkg::REQ_UPD));
      wait_idle();
      csr_write(snfu_pkg::CSR_LR, 16'h0800);
      send_req(rand_req(snfu_pkg::REQ_UPD));
      send_req(rand_req(snfu_pkg::REQ_FWD));
      wait_idle();
   endtask

   // forward/update training pairs under changing settings, some noise mixed in
   task automatic test_random_learning();
      int sent, pick;
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: apply_setting(8, 32767, 16'h7FFF);
            1: apply_setting(1, 0, 16'h8000);
            2: apply_setting(0, $urandom_range(4096), rand_q16());
            default: begin
               pick = ($urandom_range(7) == 0) ? $urandom_range(9, 15) : $urandom_range(8);
               apply_setting(pick, ($urandom_range(1) ? $urandom_range(4096)
                                                      : $urandom_range(32767)), rand_q16());
            end
         endcase
         req_gap_pct = (ph % 3 == 0) ? 0 : $urandom_range(5, 50);
         rsp_stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(5, 50);
         send_req(fill_req(snfu_pkg::REQ_INIT, 16'h0000, 16'h0000));
         sent = 1;
         while (sent < 125) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               send_req(rand_req(snfu_pkg::REQ_FWD));
               send_req(rand_req(snfu_pkg::REQ_UPD));
               sent += 2;
            end else begin
               if (pick < 85) send_req(rand_req(snfu_pkg::REQ_INIT));
               else if (pick < 90) send_req(rand_req(snfu_pkg::REQ_FWD));
               else if (pick < 95) send_req(rand_req(snfu_pkg::REQ_UPD));
               else send_req(rand_req(REQ_NONE));
               sent++;
            end
         end
         wait_idle();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < rsp_stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap(100) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h", rsp_tdata);
            fail_cnt++;
         end else begin
            exp_head = expected_q.pop_front();
            if (rsp_tdata[DW-1:0] !== exp_head.activation) begin
               $error("activation: expected %0d, actual %0d", exp_head.activation,
                      $signed(rsp_tdata[DW-1:0]));
               fail_cnt++;
            end
            if (rsp_tdata[2*DW-1:DW] !== exp_head.bias_value) begin
               $error("bias_value: expected %0d, actual %0d", exp_head.bias_value,
                      $signed(rsp_tdata[2*DW-1:DW]));
               fail_cnt++;
            end
            if (rsp_tdata[2*DW] !== exp_head.saturated) begin
               $error("saturated: expected %0d, actual %0d", exp_head.saturated,
                      rsp_tdata[2*DW]);
               fail_cnt++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      build_sigmoid_lut();
      neuron_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_and_span();
      test_saturation();
      test_sensor_neuron();
      test_fan_in_overrange();
      test_random_learning();
      wait_idle();
      if (fail_cnt == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
